>>> sv/hsvc_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// No dependencies; every other file of the block refers to it by scoped names.
package hsvc_pkg;

   // Fixed-point scale of the saturation-weight product: 255 * 2^16.
   localparam int unsigned DenomValue = 255 * 65536;
   localparam logic [23:0] DENOM = 24'(DenomValue);
   // Half of the scale, added before the divide to round to nearest.
   localparam logic [31:0] HALF_DENOM = 32'(DenomValue / 2);

   localparam int unsigned HUE_W  = 16;
   localparam int unsigned CHAN_W = 8;
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned WGT_W  = 24;
   localparam int unsigned NUM_W  = 32;

   localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

   // Sector of the hue circle; codes above five are routed like five.
   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

endpackage

>>> sv/hsvc_req_if.sv
// Input channel of the HSV to RGB converter: valid/ready plus one HSV pixel.
// Depends on hsvc_pkg for field widths.
interface hsvc_req_if;
   logic                           valid;
   logic                           ready;
   logic [hsvc_pkg::HUE_W-1:0]     hue;
   logic [hsvc_pkg::CHAN_W-1:0]    saturation;
   logic [hsvc_pkg::CHAN_W-1:0]    brightness;
   logic [hsvc_pkg::CHAN_W-1:0]    alpha_in;

   modport source (output valid, output hue, output saturation, output brightness,
                   output alpha_in, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   input alpha_in, output ready);
endinterface

>>> sv/hsvc_rsp_if.sv
// Result channel of the HSV to RGB converter: valid/ready plus one RGBA pixel.
// Depends on hsvc_pkg for field widths.
interface hsvc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hsvc_pkg::CHAN_W-1:0]    red;
   logic [hsvc_pkg::CHAN_W-1:0]    green;
   logic [hsvc_pkg::CHAN_W-1:0]    blue;
   logic [hsvc_pkg::CHAN_W-1:0]    alpha_out;

   modport source (output valid, output red, output green, output blue,
                   output alpha_out, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input alpha_out, output ready);
endinterface

>>> sv/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: four-stage pipeline with elastic stalls.
// Depends on hsvc_pkg, hsvc_req_if, hsvc_rsp_if and hsvc_term.
//
// Usage:
//   req_ch carries one HSV pixel per transaction: hue (16-bit fraction of a
//   full turn), saturation and brightness (8-bit, x/255) and alpha_in.
//   rsp_ch returns red, green, blue (rounded to nearest, clamped to 0..255)
//   and alpha_out, a copy of alpha_in, one result per pixel, in order.
//   A pixel accepted on req_ch shows on rsp_ch once it has passed the four
//   register stages in order (hue split, weight multiply, brightness
//   multiply, divide and route), the last being the output register.
//   Throughput: one pixel per clock while rsp_ch.ready stays high.
//   Each stage holds its own valid bit and advances when the stage after it
//   is empty or moving, so bubbles close up during a stall. When the receiver
//   stalls, the output register holds its result and req_ch.ready drops only
//   once all four stages are full; nothing is lost or repeated.
//   Reset (synchronous, active high) empties the pipeline; req_ch.ready is
//   high in the first cycle after reset.
module hsv_to_rgb_converter (
   input  logic         clock,
   input  logic         reset,
   hsvc_req_if.sink     req_ch,
   hsvc_rsp_if.source   rsp_ch
);

   // Stage enables: a stage loads when it is empty or the next one loads.
   logic adv1, adv2, adv3, adv4;

   logic valid1_ff, valid1_in, valid2_ff, valid2_in;
   logic valid3_ff, valid3_in, valid4_ff, valid4_in;

   // Stage 1: sector and fractional position.
   logic [hsvc_pkg::HUE_W+2:0]     hue6;
   hsvc_pkg::sector_type           sector1_ff, sector2_ff, sector3_ff;
   logic [hsvc_pkg::FRAC_W-1:0]    frac1_ff;
   logic [hsvc_pkg::CHAN_W-1:0]    sat1_ff;
   logic [hsvc_pkg::CHAN_W-1:0]    val1_ff, val2_ff, val3_ff;
   logic [hsvc_pkg::CHAN_W-1:0]    alpha1_ff, alpha2_ff, alpha3_ff, alpha4_ff;

   // Stage 2: weights DENOM - s*x for p, q and t.
   logic [hsvc_pkg::WGT_W-1:0]     sat_frac;
   logic [hsvc_pkg::WGT_W-1:0]     sat_full;
   logic [hsvc_pkg::WGT_W-1:0]     wp_in, wq_in, wt_in;
   logic [hsvc_pkg::WGT_W-1:0]     wp_ff, wq_ff, wt_ff;

   // Stage 3 term registers live in hsvc_term; stage 4 is the output register.
   logic [hsvc_pkg::CHAN_W-1:0]    term_p, term_q, term_t;
   logic [hsvc_pkg::CHAN_W-1:0]    red_in, green_in, blue_in;
   logic [hsvc_pkg::CHAN_W-1:0]    red_ff, green_ff, blue_ff;

   assign adv4 = !valid4_ff || rsp_ch.ready;
   assign adv3 = !valid3_ff || adv4;
   assign adv2 = !valid2_ff || adv3;
   assign adv1 = !valid1_ff || adv2;

   assign req_ch.ready = adv1;

   assign valid1_in = adv1 ? req_ch.valid : valid1_ff;
   assign valid2_in = adv2 ? valid1_ff    : valid2_ff;
   assign valid3_in = adv3 ? valid2_ff    : valid3_ff;
   assign valid4_in = adv4 ? valid3_ff    : valid4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
         valid4_ff <= valid4_in;
      end
   end

   assign hue6 = (hsvc_pkg::HUE_W+3)'(req_ch.hue) * (hsvc_pkg::HUE_W+3)'(6);

   always_ff @(posedge clock) begin
      if (adv1) begin
         sector1_ff <= hsvc_pkg::sector_type'(hue6[hsvc_pkg::HUE_W+2:hsvc_pkg::HUE_W]);
         frac1_ff   <= hue6[hsvc_pkg::FRAC_W-1:0];
         sat1_ff    <= req_ch.saturation;
         val1_ff    <= req_ch.brightness;
         alpha1_ff  <= req_ch.alpha_in;
      end
   end

   // s*(1-f) is s*1 - s*f, so one multiplier serves q and t.
   assign sat_frac = hsvc_pkg::WGT_W'(sat1_ff) * hsvc_pkg::WGT_W'(frac1_ff);
   assign sat_full = {sat1_ff, {hsvc_pkg::FRAC_W{1'b0}}};
   assign wp_in    = hsvc_pkg::DENOM - sat_full;
   assign wq_in    = hsvc_pkg::DENOM - sat_frac;
   assign wt_in    = hsvc_pkg::DENOM - sat_full + sat_frac;

   always_ff @(posedge clock) begin
      if (adv2) begin
         wp_ff      <= wp_in;
         wq_ff      <= wq_in;
         wt_ff      <= wt_in;
         sector2_ff <= sector1_ff;
         val2_ff    <= val1_ff;
         alpha2_ff  <= alpha1_ff;
      end
   end

   hsvc_term u_term_p (
      .clock      (clock),
      .advance    (adv3),
      .brightness (val2_ff),
      .weight     (wp_ff),
      .term       (term_p)
   );

   hsvc_term u_term_q (
      .clock      (clock),
      .advance    (adv3),
      .brightness (val2_ff),
      .weight     (wq_ff),
      .term       (term_q)
   );

   hsvc_term u_term_t (
      .clock      (clock),
      .advance    (adv3),
      .brightness (val2_ff),
      .weight     (wt_ff),
      .term       (term_t)
   );

   always_ff @(posedge clock) begin
      if (adv3) begin
         sector3_ff <= sector2_ff;
         val3_ff    <= val2_ff;
         alpha3_ff  <= alpha2_ff;
      end
   end

   // Zero saturation needs no route of its own: p, q and t all equal v then.
   always_comb begin
      case (sector3_ff)
         hsvc_pkg::SECTOR_0: begin
            red_in = val3_ff; green_in = term_t;  blue_in = term_p;
         end
         hsvc_pkg::SECTOR_1: begin
            red_in = term_q;  green_in = val3_ff; blue_in = term_p;
         end
         hsvc_pkg::SECTOR_2: begin
            red_in = term_p;  green_in = val3_ff; blue_in = term_t;
         end
         hsvc_pkg::SECTOR_3: begin
            red_in = term_p;  green_in = term_q;  blue_in = val3_ff;
         end
         hsvc_pkg::SECTOR_4: begin
            red_in = term_t;  green_in = term_p;  blue_in = val3_ff;
         end
         default: begin
            red_in = val3_ff; green_in = term_p;  blue_in = term_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         alpha4_ff <= alpha3_ff;
      end
   end

   assign rsp_ch.valid     = valid4_ff;
   assign rsp_ch.red       = red_ff;
   assign rsp_ch.green     = green_ff;
   assign rsp_ch.blue      = blue_ff;
   assign rsp_ch.alpha_out = alpha4_ff;

   // Reset empties every stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !valid1_ff && !valid2_ff && !valid3_ff && !valid4_ff)
      else $error("pipeline not empty after reset");

   // Input backpressure only when every stage holds a transaction.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> valid1_ff && valid2_ff && valid3_ff && valid4_ff)
      else $error("input stalled with an empty stage");

   // A transaction in stage 3 moves into the output register when it is free.
   a_stage3_moves: assert property (@(posedge clock) disable iff (reset)
      valid3_ff && adv4 |=> valid4_ff)
      else $error("transaction lost between stage 3 and output");

   // A held stage 3 keeps its valid bit, routing code and alpha.
   a_stage3_holds: assert property (@(posedge clock) disable iff (reset)
      valid3_ff && !adv3 |=> valid3_ff && $stable(sector3_ff) && $stable(alpha3_ff))
      else $error("stalled stage 3 changed");

endmodule

>>> sv/hsvc_term.sv
// One colour term v*(1 - s*x): multiply by brightness, round and drop 16 bits,
// register, then divide by 255 and clamp. Depends on hsvc_pkg.
module hsvc_term (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [hsvc_pkg::CHAN_W-1:0]   brightness,
   input  logic [hsvc_pkg::WGT_W-1:0]    weight,
   output logic [hsvc_pkg::CHAN_W-1:0]   term
);

   logic [hsvc_pkg::NUM_W-1:0]  num;
   logic [15:0]                 scaled_in;
   logic [15:0]                 scaled_ff;
   logic [16:0]                 div_sum;
   logic [8:0]                  quotient;

   // Rounded numerator; it stays below 2^32 for every input.
   assign num = hsvc_pkg::NUM_W'(brightness) * hsvc_pkg::NUM_W'(weight)
                + hsvc_pkg::HALF_DENOM;
   assign scaled_in = num[31:16];

   always_ff @(posedge clock) begin
      if (advance) begin
         scaled_ff <= scaled_in;
      end
   end

   // Exact floor(y/255) for y up to 65534: (y + (y >> 8) + 1) >> 8.
   assign div_sum  = {1'b0, scaled_ff} + 17'(scaled_ff[15:8]) + 17'd1;
   assign quotient = div_sum[16:8];
   assign term     = (quotient > 9'(hsvc_pkg::CHAN_MAX)) ? hsvc_pkg::CHAN_MAX
                                                         : quotient[7:0];

endmodule
